/* hdl/rfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants for the RTTY frame serialiser.
// -----------------------------------------------------------------------------
package rfs_pkg;

   // Message buffer geometry (power of two; positions wrap modulo depth)
   localparam int BUFFER_DEPTH = 256;
   localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

   localparam int BYTE_W = 8;
   localparam int POS_W  = 9;     // read position and message length
   localparam int CNT_W  = 8;     // bit counter / idle count

   localparam logic [CNT_W-1:0] CHAR_LAST_BIT = CNT_W'(7);
   localparam logic [CNT_W-1:0] IDLE_RESET    = CNT_W'(10);

   localparam logic LINE_MARK  = 1'b1;
   localparam logic LINE_SPACE = 1'b0;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_ARM   = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_CHAR  = 3'd2,
      PH_STOP1 = 3'd3,
      PH_STOP2 = 3'd4
   } phase_type;

   // Position reduced to a buffer address (modulo the depth)
   function automatic logic [BUF_AW-1:0] buf_addr(input logic [POS_W-1:0] pos);
      logic [BUF_AW+POS_W-1:0] wide;
      wide = {{BUF_AW{1'b0}}, pos};
      return wide[BUF_AW-1:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/rfs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rfs_ram
// Generic single-write, single-read RAM with registered read (write-first).
// -----------------------------------------------------------------------------
module rfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // same-address write passes straight through
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/rtty_frame_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rtty_frame_serializer
// Sends a buffered message as 7N2 RTTY line bits, one bit per tick beat.
// -----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// req      in   req_tvalid/req_tready   tuser: kind; tdata: index, value, length
// rsp      out  rsp_tvalid/rsp_tready   tdata: data_line, radio_on, pending
// csr      in   csr_valid/csr_ready     csr_data: idle_bit_count
//
// One result beat per request beat, in the cycle after it; one beat per cycle.
// The rate is set by the single result register: a request is taken whenever
// it is empty or being drained, so only a stalled rsp side holds off req.
// The message buffer is a registered-read RAM addressed by the next read
// position, so the start-bit tick finds the character already fetched.
// Synchronous reset clears control state; the buffer contents are left as is.
// -----------------------------------------------------------------------------
module rtty_frame_serializer (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // request: [7:0] byte_index, [15:8] byte_value, [24:16] message_length
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [31:0] req_tdata,
   input  wire  logic [1:0]  req_tuser,   // [1:0] kind
   // result: [0] data_line, [1] radio_on, [2] message_pending
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [7:0]        rsp_tdata,
   // idle mark bit count
   input  wire  logic        csr_valid,
   output logic              csr_ready,
   input  wire  logic [7:0]  csr_data
);

   // ---- request fields ----
   logic [rfs_pkg::BYTE_W-1:0] req_index;
   logic [rfs_pkg::BYTE_W-1:0] req_value;
   logic [rfs_pkg::POS_W-1:0]  req_length;
   logic                       req_accept;

   assign req_index  = req_tdata[7:0];
   assign req_value  = req_tdata[15:8];
   assign req_length = req_tdata[24:16];

   // ---- state ----
   rfs_pkg::phase_type         phase_ff,   phase_in;
   logic                       pending_ff, pending_in;
   logic                       active_ff,  active_in;
   logic [rfs_pkg::POS_W-1:0]  length_ff,  length_in;
   logic [rfs_pkg::POS_W-1:0]  rd_pos_ff,  rd_pos_in;
   logic [rfs_pkg::CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [rfs_pkg::BYTE_W-1:0] shift_ff,   shift_in;
   logic                       line_ff,    line_in;
   logic [rfs_pkg::CNT_W-1:0]  idle_cnt_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_data_ff,  rsp_data_in;

   logic [rfs_pkg::POS_W-1:0]  pos_inc;
   logic [rfs_pkg::CNT_W-1:0]  cnt_inc;
   logic                       buf_wr_en;
   logic [rfs_pkg::BYTE_W-1:0] buf_rd_data;

   // result register drains or is empty -> take the next beat
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign buf_wr_en = req_accept && (req_tuser == rfs_pkg::KIND_WRITE);

   // ---- message buffer ----
   rfs_ram #(
      .WIDTH (rfs_pkg::BYTE_W),
      .DEPTH (rfs_pkg::BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (rfs_pkg::buf_addr({1'b0, req_index})),
      .wr_data (req_value),
      .rd_addr (rfs_pkg::buf_addr(rd_pos_in)),
      .rd_data (buf_rd_data)
   );

   // ---- next state ----
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      length_in  = length_ff;
      rd_pos_in  = rd_pos_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      line_in    = line_ff;
      cnt_inc    = bit_cnt_ff + rfs_pkg::CNT_W'(1);
      pos_inc    = '0;

      if (req_accept) begin
         // radio enable follows pending one beat late
         if (pending_ff && !active_ff) begin
            active_in = 1'b1;
            rd_pos_in = '0;
         end else if (!pending_ff && active_ff) begin
            active_in = 1'b0;
         end

         pos_inc = rd_pos_in + rfs_pkg::POS_W'(1);

         case (req_tuser)
            rfs_pkg::KIND_WRITE: begin
               // handled by the buffer write port
            end
            rfs_pkg::KIND_ARM: begin
               length_in  = req_length;
               pending_in = 1'b1;
            end
            rfs_pkg::KIND_TICK: begin
               if (pending_ff) begin
                  case (phase_ff)
                     rfs_pkg::PH_IDLE: begin
                        line_in    = rfs_pkg::LINE_MARK;
                        bit_cnt_in = cnt_inc;
                        if (cnt_inc == idle_cnt_ff) begin
                           phase_in   = rfs_pkg::PH_START;
                           bit_cnt_in = '0;
                        end
                     end
                     rfs_pkg::PH_START: begin
                        line_in    = rfs_pkg::LINE_SPACE;
                        bit_cnt_in = '0;
                        shift_in   = buf_rd_data;
                        phase_in   = rfs_pkg::PH_CHAR;
                     end
                     rfs_pkg::PH_CHAR: begin
                        bit_cnt_in = cnt_inc;
                        line_in    = shift_ff[0];
                        shift_in   = {1'b0, shift_ff[rfs_pkg::BYTE_W-1:1]};
                        if (cnt_inc == rfs_pkg::CHAR_LAST_BIT) begin
                           phase_in = rfs_pkg::PH_STOP1;
                        end
                     end
                     rfs_pkg::PH_STOP1: begin
                        line_in  = rfs_pkg::LINE_MARK;
                        phase_in = rfs_pkg::PH_STOP2;
                     end
                     rfs_pkg::PH_STOP2: begin
                        bit_cnt_in = '0;
                        rd_pos_in  = pos_inc;
                        // end test after each character: zero length sends one
                        if (pos_inc >= length_ff) begin
                           phase_in   = rfs_pkg::PH_IDLE;
                           pending_in = 1'b0;
                        end else begin
                           phase_in = rfs_pkg::PH_START;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
               // unused kind: enable step only
            end
         endcase
      end
   end

   // ---- result beat ----
   always_comb begin
      rsp_data_in = {5'b0, pending_in, active_in, line_in};
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rfs_pkg::PH_IDLE;
         pending_ff   <= 1'b0;
         active_ff    <= 1'b0;
         length_ff    <= '0;
         rd_pos_ff    <= '0;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         line_ff      <= rfs_pkg::LINE_MARK;
         idle_cnt_ff  <= rfs_pkg::IDLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         active_ff    <= active_in;
         length_ff    <= length_in;
         rd_pos_ff    <= rd_pos_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            idle_cnt_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions ----
   // framing only runs while a message is armed
   a_phase_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rfs_pkg::PH_IDLE) |-> pending_ff)
      else $error("framing phase active with no pending message");

   // character phase never holds a finished bit count
   a_char_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rfs_pkg::PH_CHAR) |-> (bit_cnt_ff < rfs_pkg::CHAR_LAST_BIT))
      else $error("bit counter overran in character phase");

   // every accepted request leaves a result beat behind
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result beat");

endmodule
`default_nettype wire

/* verif/rtty_frame_serializer_test.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtty_frame_serializer_test
// Self-checking bench for the RTTY frame serialiser. Request beats (byte
// writes, arming, bit ticks, unused kinds) go in with random gaps, and result
// beats are taken with random stalls and one long hold-off. A line-status
// predictor computes the expected beat for every accepted request, and each
// result beat is compared field by field with the oldest expected one.
// -----------------------------------------------------------------------------
module rtty_frame_serializer_test;

   // The kind field is two bits wide; the fourth code has no action of its own
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int CLOCK_HALF_NS    = 6;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 4;     // covers the result register, plus margin
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int MAX_REPORTS      = 10;
   localparam int TIMEOUT_NS       = 3_000_000;

   typedef struct packed {
      logic message_pending;
      logic radio_on;
      logic data_line;
   } line_status_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [7:0] byte_index, [15:8] byte_value, [24:16] message_length
   logic [1:0]  req_tuser;    // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [0] data_line, [1] radio_on, [2] message_pending
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;     // idle mark bit count

   // Idling controls, set by the test sequence and read by send_beat and the ready driver
   bit req_gaps_on      = 1'b1;
   bit rsp_stalls_on    = 1'b1;
   bit long_hold_wanted = 1'b0;

   int failures   = 0;
   int live_beats = 0;        // beats that the block acts on (ignored ones excluded)

   line_status_type line_status_q[$];

   // Predictor state: a private copy of the serialiser
   logic [rfs_pkg::BYTE_W-1:0] msg_store [rfs_pkg::BUFFER_DEPTH];
   bit                         byte_written [rfs_pkg::BUFFER_DEPTH];
   logic                       msg_armed;
   logic                       tx_enabled;
   logic                       line_bit;
   logic [rfs_pkg::POS_W-1:0]  msg_length;
   logic [rfs_pkg::POS_W-1:0]  char_pos;
   rfs_pkg::phase_type         frame_state;
   logic [rfs_pkg::CNT_W-1:0]  bits_done;
   logic [rfs_pkg::BYTE_W-1:0] char_shift;
   logic [rfs_pkg::CNT_W-1:0]  idle_bits;

   rtty_frame_serializer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // One line bit of 7N2 framing: idle marks, start space, 7 data bits LSB
   // first, two stop marks. The end test follows each character, so a zero
   // length still sends the character at position 0.
   function automatic void shift_line_bit();
      case (frame_state)
         rfs_pkg::PH_IDLE: begin
            line_bit  = rfs_pkg::LINE_MARK;
            bits_done = bits_done + 1'b1;     // wraps, so a count of 0 means 256
            if (bits_done == idle_bits) begin
               frame_state = rfs_pkg::PH_START;
               bits_done   = '0;
            end
         end
         rfs_pkg::PH_START: begin
            line_bit    = rfs_pkg::LINE_SPACE;
            bits_done   = '0;
            char_shift  = msg_store[char_pos % rfs_pkg::BUFFER_DEPTH];
            frame_state = rfs_pkg::PH_CHAR;
         end
         rfs_pkg::PH_CHAR: begin
            bits_done  = bits_done + 1'b1;
            line_bit   = char_shift[0];
            char_shift = char_shift >> 1;
            if (bits_done == rfs_pkg::CHAR_LAST_BIT) begin
               frame_state = rfs_pkg::PH_STOP1;
            end
         end
         rfs_pkg::PH_STOP1: begin
            line_bit    = rfs_pkg::LINE_MARK;
            frame_state = rfs_pkg::PH_STOP2;
         end
         rfs_pkg::PH_STOP2: begin
            bits_done   = '0;
            frame_state = rfs_pkg::PH_START;
            char_pos    = char_pos + 1'b1;
            if (char_pos >= msg_length) begin
               frame_state = rfs_pkg::PH_IDLE;
               msg_armed   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic line_status_type predict_line_status(input logic [1:0] kind,
                                                           input logic [7:0] idx,
                                                           input logic [7:0] val,
                                                           input logic [8:0] len);
      line_status_type st;
      // Radio follows the armed flag one beat late; keying up restarts at position 0
      if (msg_armed && !tx_enabled) begin
         tx_enabled = 1'b1;
         char_pos   = '0;
      end else if (!msg_armed && tx_enabled) begin
         tx_enabled = 1'b0;
      end
      case (kind)
         rfs_pkg::KIND_WRITE: begin
            msg_store[idx] = val;
         end
         rfs_pkg::KIND_ARM: begin
            msg_length = len;
            msg_armed  = 1'b1;
         end
         rfs_pkg::KIND_TICK: begin
            if (msg_armed) begin
               shift_line_bit();
            end
         end
         default: begin
         end
      endcase
      st.data_line       = line_bit;
      st.radio_on        = tx_enabled;
      st.message_pending = msg_armed;
      return st;
   endfunction

   // Length of the run of written buffer entries from position 0; messages
   // never read past it, so no unwritten entry is ever fetched.
   function automatic int written_prefix();
      int n;
      n = 0;
      while (n < rfs_pkg::BUFFER_DEPTH && byte_written[n]) begin
         n++;
      end
      return n;
   endfunction

   function automatic logic [8:0] pick_length(input int run);
      int top;
      top = (run < 6) ? run : 6;
      if ($urandom_range(0, 15) == 0) begin
         top = (run < 24) ? run : 24;
      end
      return 9'($urandom_range(0, top));
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, what);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: ready driver and checker
   // ---------------------------------------------------------------------------

   // Random stall bursts, plus one long hold-off on request
   initial begin : drive_rsp_ready
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!rsp_stalls_on) begin
            stall_left = 0;
         end
         if (long_hold_wanted) begin
            hold_left        = LONG_HOLD_CYCLES;
            long_hold_wanted = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // An unknown valid counts as a beat so that it cannot slip past unchecked
   always @(posedge clock) begin : check_line_status
      line_status_type want;
      if (!reset && rsp_tready && rsp_tvalid !== 1'b0) begin
         if (line_status_q.size() == 0) begin
            note_failure($sformatf("result beat %b with nothing expected", rsp_tdata[2:0]));
         end else begin
            want = line_status_q.pop_front();
            if (rsp_tdata[0] !== want.data_line) begin
               note_failure($sformatf("data_line: expected %b, got %b",
                                      want.data_line, rsp_tdata[0]));
            end
            if (rsp_tdata[1] !== want.radio_on) begin
               note_failure($sformatf("radio_on: expected %b, got %b",
                                      want.radio_on, rsp_tdata[1]));
            end
            if (rsp_tdata[2] !== want.message_pending) begin
               note_failure($sformatf("message_pending: expected %b, got %b",
                                      want.message_pending, rsp_tdata[2]));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Drive one request beat at the falling edge, hold it until taken, then
   // predict. Back-to-back beats keep tvalid high with a single assignment.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] idx,
                            input logic [7:0] val, input logic [8:0] len);
      int gap;
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, len, val, idx};
      do @(posedge clock); while (!req_tready);
      if (kind != KIND_UNUSED && (kind != rfs_pkg::KIND_TICK || msg_armed)) begin
         live_beats++;
      end
      line_status_q.push_back(predict_line_status(kind, idx, val, len));
   endtask

   // Fields that the kind does not use carry random values
   task automatic write_byte(input logic [7:0] idx, input logic [7:0] val);
      byte_written[idx] = 1'b1;
      send_beat(rfs_pkg::KIND_WRITE, idx, val, 9'($urandom));
   endtask

   task automatic arm_message(input logic [8:0] len);
      send_beat(rfs_pkg::KIND_ARM, 8'($urandom), 8'($urandom), len);
   endtask

   task automatic tick_beat();
      send_beat(rfs_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 9'($urandom));
   endtask

   task automatic stray_beat();
      send_beat(KIND_UNUSED, 8'($urandom), 8'($urandom), 9'($urandom));
   endtask

   // Tick until the last stop bit is out, then one more beat to drop the radio
   task automatic run_out_message();
      while (msg_armed) begin
         tick_beat();
      end
      stray_beat();
   endtask

   // Stop offering and wait until every expected beat is back
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (line_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle_bits(input logic [7:0] count);
      settle_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      idle_bits = count;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Ignored beats, field extremes, and a zero-length message at the reset idle count
   task automatic test_framing_basics();
      tick_beat();                       // nothing armed: line stays at mark
      stray_beat();
      write_byte(8'd0, 8'hD5);
      write_byte(8'd1, 8'hFF);
      write_byte(8'd255, 8'h00);
      arm_message(9'd0);                 // still sends the character at position 0
      run_out_message();
   endtask

   // Idle count of 1, a re-arm before key-up, and 0 which wraps to 256 marks
   task automatic test_idle_counts();
      set_idle_bits(8'd1);
      arm_message(9'd256);
      repeat (12) tick_beat();           // one mark, all of char 0, start of char 1
      arm_message(9'd1);                 // new length below position: stop after char 1
      run_out_message();

      set_idle_bits(8'd3);
      arm_message(9'd2);
      arm_message(9'd1);                 // re-armed on the beat that keys the radio up
      run_out_message();

      set_idle_bits(8'd0);
      arm_message(9'd2);
      run_out_message();
   endtask

   // Results held back while requests keep coming, so the block fills and stalls
   task automatic test_back_pressure();
      set_idle_bits(8'd2);
      write_byte(8'd2, 8'($urandom));
      req_gaps_on      = 1'b0;
      long_hold_wanted = 1'b1;
      arm_message(9'd3);
      run_out_message();
      req_gaps_on = 1'b1;
   endtask

   // Mostly well-formed messages with random content, plus noise: unused
   // kinds, writes mid-message, new lengths mid-message, stray ticks.
   task automatic run_message_traffic(input int goal);
      int stop_at;
      int run;
      stop_at = live_beats + goal;
      while (live_beats < stop_at) begin
         repeat ($urandom_range(0, 3)) begin
            run = written_prefix();
            if (run < rfs_pkg::BUFFER_DEPTH && $urandom_range(0, 3) != 0) begin
               write_byte(8'(run), 8'($urandom));
            end else begin
               write_byte(8'($urandom), 8'($urandom));
            end
         end
         arm_message(pick_length(written_prefix()));
         while (msg_armed) begin
            case ($urandom_range(0, 19))
               0: begin
                  stray_beat();
               end
               1: begin
                  write_byte(8'($urandom), 8'($urandom));
               end
               2: begin
                  arm_message(pick_length(written_prefix()));
               end
               default: begin
                  tick_beat();
               end
            endcase
         end
         // Radio still on here; sometimes the next arm is what drops it
         if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 1) != 0) begin
                  tick_beat();
               end else begin
                  stray_beat();
               end
            end
            if ($urandom_range(0, 7) == 0) begin
               set_idle_bits(8'($urandom_range(1, 6)));
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      set_idle_bits(8'($urandom_range(1, 4)));
      run_message_traffic(120);
   endtask

   // Closing stretch with neither side idling
   task automatic test_steady_stream();
      settle_block();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_message_traffic(50);
   endtask

   initial begin : run_tests
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      reset      = 1'b1;

      msg_armed   = 1'b0;
      tx_enabled  = 1'b0;
      line_bit    = rfs_pkg::LINE_MARK;
      msg_length  = '0;
      char_pos    = '0;
      frame_state = rfs_pkg::PH_IDLE;
      bits_done   = '0;
      char_shift  = '0;
      idle_bits   = rfs_pkg::IDLE_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_framing_basics();
      test_idle_counts();
      test_back_pressure();
      test_random_traffic();
      test_steady_stream();
      settle_block();

      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Far beyond the slowest correct run
   initial begin : watchdog
      #TIMEOUT_NS;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
